/* src/ctb_pkg.sv */
// shared types and constants of the countdown timeout bank
package ctb_pkg;

  // field widths of one transaction
  localparam int unsigned ActionW = 2;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned CountW  = 32;
  localparam int unsigned StatusW = 2;

  // packed widths on the stream ports
  localparam int unsigned InDataW  = 40;  // index and load value, padded to bytes
  localparam int unsigned OutDataW = 8;   // status, padded to a byte

  // operation carried in the input tuser
  typedef enum logic [ActionW-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_CHECK = 2'd3
  } action_e;

  // status of one timeout
  typedef enum logic [StatusW-1:0] {
    ST_IDLE     = 2'd0,
    ST_LOADED   = 2'd1,
    ST_COUNTING = 2'd2,
    ST_OCCURRED = 2'd3
  } status_e;

  typedef logic [CountW-1:0] count_t;

endpackage

/* src/countdown_timeout_bank.sv */
// top level: bank of countdown timeouts behind stream ports
//
//   channel   | direction | tuser      | tdata (lowest bit up)
//   s_axis    | in        | action[1:0]| timer_index[2:0], load_value[34:3], zero pad
//   m_axis    | out       | -          | check_status[1:0], zero pad
//
// an input transaction is held in an input register and acted on from there
// a tick, start or stop never stalls, so one transaction per cycle is taken unless a check waits
// a check needs the result register free; it waits in the input register while m_axis is stalled
// every timeout ticks in parallel in its own counter lane
// reset returns every timeout to idle, disarmed, with a zero count
module countdown_timeout_bank #(
  parameter int unsigned NUM_TIMERS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ctb_pkg::InDataW-1:0]  s_axis_tdata,  // timer_index, load_value, pad
  input  logic [ctb_pkg::ActionW-1:0]  s_axis_tuser,  // action
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ctb_pkg::OutDataW-1:0] m_axis_tdata   // check_status, pad
);

  // input register
  logic                          in_valid_q;
  ctb_pkg::action_e              in_action_q;
  logic [ctb_pkg::IndexW-1:0]    in_index_q;
  ctb_pkg::count_t               in_load_q;

  // timeout state, one lane per timeout
  ctb_pkg::count_t               count_q  [NUM_TIMERS];
  ctb_pkg::count_t               count_d  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]         armed_q;
  logic [NUM_TIMERS-1:0]         armed_d;
  ctb_pkg::status_e              status_q [NUM_TIMERS];
  ctb_pkg::status_e              status_d [NUM_TIMERS];

  // result register
  logic                          out_valid_q;
  ctb_pkg::status_e              out_status_q;

  logic                          in_accept;
  logic                          advance;
  logic                          is_check;
  logic [NUM_TIMERS-1:0]         sel;
  ctb_pkg::status_e              rd_status;

  // an item leaves the input register unless it is a check facing a full result register
  assign is_check      = (in_action_q == ctb_pkg::ACT_CHECK);
  assign advance       = in_valid_q && (!is_check || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_action_q <= ctb_pkg::action_e'(s_axis_tuser);
      in_index_q  <= s_axis_tdata[ctb_pkg::IndexW-1:0];
      in_load_q   <= s_axis_tdata[ctb_pkg::IndexW +: ctb_pkg::CountW];
    end
  end

  // lane select; an index beyond the bank selects nothing
  always_comb begin
    for (int unsigned t = 0; t < NUM_TIMERS; t++) begin
      sel[t] = (32'(in_index_q) == t);
    end
  end

  // status read for a check, idle when nothing is selected
  always_comb begin
    rd_status = ctb_pkg::ST_IDLE;
    for (int unsigned t = 0; t < NUM_TIMERS; t++) begin
      if (sel[t]) begin
        rd_status = status_q[t];
      end
    end
  end

  // next state of every lane
  always_comb begin
    for (int unsigned t = 0; t < NUM_TIMERS; t++) begin
      count_d[t]  = count_q[t];
      armed_d[t]  = armed_q[t];
      status_d[t] = status_q[t];
      if (advance) begin
        case (in_action_q)
          ctb_pkg::ACT_TICK: begin
            if (armed_q[t]) begin
              if (count_q[t] != '0) begin
                count_d[t]  = count_q[t] - ctb_pkg::count_t'(1);
                status_d[t] = ctb_pkg::ST_COUNTING;
              end else begin
                status_d[t] = ctb_pkg::ST_OCCURRED;
                armed_d[t]  = 1'b0;
              end
            end
          end
          ctb_pkg::ACT_START: begin
            if (sel[t]) begin
              count_d[t]  = in_load_q;
              armed_d[t]  = 1'b1;
              status_d[t] = ctb_pkg::ST_LOADED;
            end
          end
          ctb_pkg::ACT_STOP: begin
            if (sel[t]) begin
              count_d[t]  = '0;
              armed_d[t]  = 1'b0;
              status_d[t] = ctb_pkg::ST_IDLE;
            end
          end
          ctb_pkg::ACT_CHECK: begin
            // reading an occurred timeout clears it
            if (sel[t] && status_q[t] == ctb_pkg::ST_OCCURRED) begin
              status_d[t] = ctb_pkg::ST_IDLE;
            end
          end
          default: begin
            status_d[t] = status_q[t];
          end
        endcase
      end
    end
  end

  // timeout state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned t = 0; t < NUM_TIMERS; t++) begin
        count_q[t]  <= '0;
        status_q[t] <= ctb_pkg::ST_IDLE;
      end
      armed_q <= '0;
    end else begin
      for (int unsigned t = 0; t < NUM_TIMERS; t++) begin
        count_q[t]  <= count_d[t];
        status_q[t] <= status_d[t];
      end
      armed_q <= armed_d;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_check) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance && is_check) begin
      out_status_q <= rd_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ctb_pkg::OutDataW - ctb_pkg::StatusW){1'b0}}, out_status_q};

endmodule
